[rtl/quadrant_polynomial_image_warp_macros.svh]
// Assertion macros for the warp RTL.
`ifndef QUADRANT_POLYNOMIAL_IMAGE_WARP_MACROS_SVH
`define QUADRANT_POLYNOMIAL_IMAGE_WARP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define QPIW_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define QPIW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/qpiw_pkg.sv]
// Types and constants of the quadrant polynomial image warp.
`timescale 1ns / 1ps
`default_nettype none
package qpiw_pkg;
	localparam int IDX_W       = 10;
	localparam int FRAC_W      = 16;
	localparam int LIN_W       = 26;
	localparam int QUAD_W      = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DIAG_LIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIAG_QUAD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_LIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_QX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_QY   = 3'd4;

	localparam logic [LIN_W-1:0]  RST_DIAG_LIN  = 26'd35573570;
	localparam logic [QUAD_W-1:0] RST_DIAG_QUAD = 32'd27764731;
	localparam logic [LIN_W-1:0]  RST_LEFT_LIN  = 26'd35713995;
	localparam logic [QUAD_W-1:0] RST_LEFT_QX   = 32'd28044031;
	localparam logic [QUAD_W-1:0] RST_LEFT_QY   = 32'd27874080;

	typedef struct packed {
		logic       opcode;
		logic [8:0] row;
		logic [8:0] col;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       outside;
	} out_item_t;

	typedef struct packed {
		logic [LIN_W-1:0]  lin_diag;
		logic [QUAD_W-1:0] quad_diag;
		logic [LIN_W-1:0]  lin_left;
		logic [QUAD_W-1:0] quad_left_x;
		logic [QUAD_W-1:0] quad_left_y;
	} gains_t;

	// One unit of work for the back end: a store or a resolved query.
	typedef struct packed {
		logic              is_store;
		logic              outside;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [FRAC_W-1:0] frac_r;
		logic [FRAC_W-1:0] frac_c;
		logic [23:0]       rgb;
	} job_t;
endpackage
`default_nettype wire

[rtl/qpiw_front.sv]
// Front end: accepts items, maps query pixels to source points.
`timescale 1ns / 1ps
`default_nettype none
module qpiw_front #(
	parameter int IMAGE_SIZE = 328
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire qpiw_pkg::in_item_t in_data,
	input  wire qpiw_pkg::gains_t  gains,
	input  wire logic              queue_full,
	output logic                   push,
	output qpiw_pkg::job_t         push_job
);
	import qpiw_pkg::*;

	localparam int CW    = ($clog2(IMAGE_SIZE) > 9) ? $clog2(IMAGE_SIZE) + 3 : 12;
	localparam int SQW   = 2 * CW;
	localparam int ACC_W = 64;
	localparam int LPW   = LIN_W + CW + 1;
	localparam int QPW   = QUAD_W + SQW + 2;
	localparam logic signed [ACC_W-1:0] P_OFS = ACC_W'(IMAGE_SIZE) * 65536 - 32768;
	localparam logic signed [ACC_W-1:0] HALF  = 32768;
	localparam logic signed [ACC_W-1:0] LIM   = ACC_W'(IMAGE_SIZE - 1) * 65536;

	typedef enum logic [2:0] {F_IDLE, F_SQR, F_LIN, F_QUAD1, F_QUAD2, F_FIN} fstate_t;
	typedef enum logic [1:0] {TRI_BOTTOM, TRI_LEFT, TRI_TOP, TRI_RIGHT} tri_t;

	fstate_t                  state_q;
	tri_t                     tri_q;
	logic signed [CW-1:0]     x2_q, y2_q, d_q;
	logic signed [SQW-1:0]    xx_q, yy_q;
	logic signed [SQW:0]      qop_q;
	logic [LIN_W-1:0]         lin_gain_q;
	logic [QUAD_W-1:0]        qgain_q;
	logic                     adj_v_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic                     accept, in_range;
	logic signed [CW:0]       sum_xy;
	logic signed [LPW-1:0]    lin_prod;
	logic signed [QPW-1:0]    quad_prod;
	logic signed [ACC_W-1:0]  lin_ext, quad_ext, x_ext, y_ext, base;
	logic signed [ACC_W-1:0]  u34, v34, p, q;
	logic                     outside;
	job_t                     fin_job, direct_job;

	assign in_stall = (state_q != F_IDLE) || queue_full;
	assign accept   = in_valid && !in_stall;
	assign in_range = (32'(in_data.row) < IMAGE_SIZE) && (32'(in_data.col) < IMAGE_SIZE);

	assign sum_xy    = (CW+1)'(x2_q) + (CW+1)'(y2_q);
	assign lin_prod  = LPW'($signed({1'b0, lin_gain_q})) * LPW'(d_q);
	assign quad_prod = QPW'($signed({1'b0, qgain_q})) * QPW'(qop_q);
	assign lin_ext   = ACC_W'(lin_prod);
	assign quad_ext  = ACC_W'(quad_prod);
	assign x_ext     = ACC_W'(x2_q);
	assign y_ext     = ACC_W'(y2_q);
	assign base      = adj_v_q ? (y_ext <<< 33) : (x_ext <<< 33);

	assign u34 = adj_v_q ? (x_ext <<< 33) : acc_q;
	assign v34 = adj_v_q ? acc_q : (y_ext <<< 33);
	// floor to Q.16 is an arithmetic shift
	assign p = P_OFS - (v34 >>> 18);
	assign q = (u34 >>> 18) - HALF;
	assign outside = (p < 0) || (p > LIM) || (q < 0) || (q > LIM);

	always_comb begin
		fin_job          = '0;
		fin_job.is_store = 1'b0;
		fin_job.outside  = outside;
		fin_job.row      = p[FRAC_W +: IDX_W];
		fin_job.col      = q[FRAC_W +: IDX_W];
		fin_job.frac_r   = p[FRAC_W-1:0];
		fin_job.frac_c   = q[FRAC_W-1:0];

		direct_job          = '0;
		direct_job.is_store = (in_data.opcode == OP_STORE);
		direct_job.outside  = 1'b1;
		direct_job.row      = IDX_W'(in_data.row);
		direct_job.col      = IDX_W'(in_data.col);
		direct_job.rgb      = {in_data.red_in, in_data.green_in, in_data.blue_in};
	end

	always_comb begin
		if (state_q == F_FIN) begin
			push     = !queue_full;
			push_job = fin_job;
		end else begin
			// stores in range and out-of-range queries go straight through
			push     = accept && ((in_data.opcode == OP_STORE) == in_range);
			push_job = direct_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && in_data.opcode == OP_QUERY && in_range) begin
						x2_q    <= $signed(CW'({in_data.col, 1'b1}));
						y2_q    <= $signed(CW'(2 * IMAGE_SIZE - 1)) -
							$signed(CW'({in_data.row, 1'b0}));
						state_q <= F_SQR;
					end
				end
				F_SQR: begin
					xx_q <= SQW'(x2_q) * SQW'(x2_q);
					yy_q <= SQW'(y2_q) * SQW'(y2_q);
					priority if (y2_q <= x2_q && sum_xy <= $signed((CW+1)'(2 * IMAGE_SIZE))) begin
						tri_q      <= TRI_BOTTOM;
						d_q        <= y2_q - x2_q;
						lin_gain_q <= gains.lin_diag;
						adj_v_q    <= 1'b1;
					end else if (y2_q >= x2_q &&
							sum_xy <= $signed((CW+1)'(2 * IMAGE_SIZE))) begin
						tri_q      <= TRI_LEFT;
						d_q        <= x2_q - y2_q;
						lin_gain_q <= gains.lin_left;
						adj_v_q    <= 1'b0;
					end else if (x2_q <= y2_q) begin
						tri_q      <= TRI_TOP;
						d_q        <= x2_q - y2_q;
						lin_gain_q <= gains.lin_diag;
						adj_v_q    <= 1'b1;
					end else begin
						tri_q      <= TRI_RIGHT;
						d_q        <= y2_q - x2_q;
						lin_gain_q <= gains.lin_diag;
						adj_v_q    <= 1'b0;
					end
					state_q <= F_LIN;
				end
				F_LIN: begin
					acc_q <= base + (lin_ext <<< 9);
					unique case (tri_q)
						TRI_LEFT: begin
							qgain_q <= gains.quad_left_x;
							qop_q   <= -(SQW+1)'(xx_q);
						end
						TRI_TOP: begin
							qgain_q <= gains.quad_diag;
							qop_q   <= (SQW+1)'(yy_q) - (SQW+1)'(xx_q);
						end
						default: begin
							qgain_q <= gains.quad_diag;
							qop_q   <= (SQW+1)'(xx_q) - (SQW+1)'(yy_q);
						end
					endcase
					state_q <= F_QUAD1;
				end
				F_QUAD1: begin
					acc_q   <= acc_q + quad_ext;
					qgain_q <= gains.quad_left_y;
					qop_q   <= (SQW+1)'(yy_q);
					state_q <= (tri_q == TRI_LEFT) ? F_QUAD2 : F_FIN;
				end
				F_QUAD2: begin
					acc_q   <= acc_q + quad_ext;
					state_q <= F_FIN;
				end
				F_FIN: begin
					// hold until the queue has room
					if (!queue_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/qpiw_queue.sv]
// Small job queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module qpiw_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire qpiw_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output qpiw_pkg::job_t      pop_job,
	output logic                not_empty
);
	import qpiw_pkg::*;

	job_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop && not_empty) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && not_empty);
		end
	end
endmodule
`default_nettype wire

[rtl/qpiw_back.sv]
// Back end: frame store, neighbour reads, bilinear blend, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrant_polynomial_image_warp_macros.svh"
module qpiw_back #(
	parameter int IMAGE_SIZE = 328
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            job_valid,
	input  wire qpiw_pkg::job_t  job,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output qpiw_pkg::out_item_t  out_data
);
	import qpiw_pkg::*;

	localparam int NPIX  = IMAGE_SIZE * IMAGE_SIZE;
	localparam int AW    = $clog2(NPIX);
	localparam int W_W   = 2 * FRAC_W + 2;
	localparam int ACC_W = 8 + W_W;

	typedef enum logic [1:0] {B_IDLE, B_READ, B_DRAIN, B_DONE} bstate_t;

	logic [23:0]      frame_q [NPIX];
	bstate_t          state_q;
	job_t             job_q;
	logic [1:0]       k_q;
	logic             rd_en_s1;
	logic [W_W-1:0]   w_s1;
	logic [23:0]      rdata_s1;
	logic [ACC_W-1:0] acc_q [3];
	logic             res_out_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             wr_en, rd_en, dr, dc, out_free;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [IDX_W-1:0] rr, cc;
	logic [FRAC_W:0]  wp, wq;

	assign pop      = (state_q == B_IDLE) && job_valid;
	assign wr_en    = pop && job.is_store;
	assign wr_addr  = AW'(job.row) * AW'(IMAGE_SIZE) + AW'(job.col);

	assign dr       = k_q[1];
	assign dc       = k_q[0];
	// skip neighbours whose weight is zero
	assign rd_en    = (state_q == B_READ) && (!dr || job_q.frac_r != '0) &&
		(!dc || job_q.frac_c != '0);
	assign rr       = job_q.row + IDX_W'(dr);
	assign cc       = job_q.col + IDX_W'(dc);
	assign rd_addr  = AW'(rr) * AW'(IMAGE_SIZE) + AW'(cc);
	assign wp       = dr ? {1'b0, job_q.frac_r} :
		(FRAC_W+1)'(1 << FRAC_W) - {1'b0, job_q.frac_r};
	assign wq       = dc ? {1'b0, job_q.frac_c} :
		(FRAC_W+1)'(1 << FRAC_W) - {1'b0, job_q.frac_c};
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (wr_en) frame_q[wr_addr] <= job.rgb;
		if (rd_en) rdata_s1 <= frame_q[rd_addr];
		w_s1 <= W_W'(wp) * W_W'(wq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			rd_en_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			rd_en_s1 <= rd_en;
			if (out_valid_q && !out_stall && state_q != B_DONE) out_valid_q <= 1'b0;
			if (rd_en_s1) begin
				for (int ch = 0; ch < 3; ch++) begin
					acc_q[ch] <= acc_q[ch] + ACC_W'(rdata_s1[16 - 8*ch +: 8]) * ACC_W'(w_s1);
				end
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop && !job.is_store) begin
						job_q     <= job;
						res_out_q <= job.outside;
						k_q       <= '0;
						for (int ch = 0; ch < 3; ch++) acc_q[ch] <= '0;
						state_q   <= job.outside ? B_DONE : B_READ;
					end
				end
				B_READ: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) state_q <= B_DRAIN;
				end
				B_DRAIN: state_q <= B_DONE;
				B_DONE: begin
					if (out_free) begin
						out_q.red_out   <= acc_q[0][2*FRAC_W +: 8];
						out_q.green_out <= acc_q[1][2*FRAC_W +: 8];
						out_q.blue_out  <= acc_q[2][2*FRAC_W +: 8];
						out_q.outside   <= res_out_q;
						out_valid_q     <= 1'b1;
						state_q         <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`QPIW_ASSERT_IMPL(a_read_query_only, rd_en, !job_q.is_store && !job_q.outside, "read for a job that is not a query inside the image")
	`QPIW_ASSERT_NEXT(a_drain_retires, state_q == B_DRAIN, !rd_en_s1, "neighbour read still in flight after drain")
	`QPIW_ASSERT_IMPL(a_store_quiet, wr_en, state_q == B_IDLE && !rd_en_s1, "store overlaps a pending neighbour read")
endmodule
`default_nettype wire

[rtl/quadrant_polynomial_image_warp.sv]
// Top level of the quadrant polynomial image warp.
// A store inside the image enters the job queue directly; a query inside
// it steps through the front end states square, linear, quadratic (again
// for the left triangle) and finish. The back end dequeues it, visits the
// four neighbours of an inside source point in turn through the single
// read port of the frame store, drains and registers the result. Front
// and back overlap through a four-entry job queue; the back end takes a
// new job only once the last result is registered. The frame store has
// no clearing pass; an unstored pixel gives an undefined sample.
`timescale 1ns / 1ps
`default_nettype none
module quadrant_polynomial_image_warp #(
	parameter int IMAGE_SIZE = 328
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire qpiw_pkg::in_item_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output qpiw_pkg::out_item_t                      out_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [qpiw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [qpiw_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import qpiw_pkg::*;

	gains_t gains_q;
	logic   push, queue_full, pop, job_valid;
	job_t   push_job, pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.lin_diag    <= RST_DIAG_LIN;
			gains_q.quad_diag   <= RST_DIAG_QUAD;
			gains_q.lin_left    <= RST_LEFT_LIN;
			gains_q.quad_left_x <= RST_LEFT_QX;
			gains_q.quad_left_y <= RST_LEFT_QY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIAG_LIN:  gains_q.lin_diag    <= cfg_data[LIN_W-1:0];
				REG_DIAG_QUAD: gains_q.quad_diag   <= cfg_data[QUAD_W-1:0];
				REG_LEFT_LIN:  gains_q.lin_left    <= cfg_data[LIN_W-1:0];
				REG_LEFT_QX:   gains_q.quad_left_x <= cfg_data[QUAD_W-1:0];
				REG_LEFT_QY:   gains_q.quad_left_y <= cfg_data[QUAD_W-1:0];
				default: ;
			endcase
		end
	end

	qpiw_front #(.IMAGE_SIZE(IMAGE_SIZE)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.gains      (gains_q),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	qpiw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.pop_job   (pop_job),
		.not_empty (job_valid)
	);

	qpiw_back #(.IMAGE_SIZE(IMAGE_SIZE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);
endmodule
`default_nettype wire

[tb/warp_checker.sv]
// Source mapping shared by stimulus and checker, and the scoreboard of the warp block.
`timescale 1ns / 1ps
package warp_map_pkg;
	localparam int N = 328;

	typedef struct {
		bit outside;
		int r0;
		int c0;
		int fp;
		int fq;
	} src_pt_t;

	// Inverse map of the triangle that holds the pixel centre, in doubled coordinates.
	function automatic src_pt_t map_source(logic [8:0] row, logic [8:0] col,
			qpiw_pkg::gains_t g);
		longint x2, y2, xx, yy, a, c, u34, v34, p, q;
		src_pt_t s;
		s.outside = 1;
		s.r0 = 0;
		s.c0 = 0;
		s.fp = 0;
		s.fq = 0;
		if (row >= N || col >= N)
			return s;
		x2 = 2 * longint'(col) + 1;
		y2 = 2 * (N - longint'(row)) - 1;
		xx = x2 * x2;
		yy = y2 * y2;
		a = longint'(g.lin_diag);
		c = longint'(g.quad_diag);
		u34 = x2 <<< 33;
		v34 = y2 <<< 33;
		if (y2 <= x2 && x2 + y2 <= 2 * N)
			v34 += a * (y2 - x2) * 512 + c * (xx - yy);
		else if (y2 >= x2 && x2 + y2 <= 2 * N)
			u34 += longint'(g.lin_left) * (x2 - y2) * 512
				- longint'(g.quad_left_x) * xx + longint'(g.quad_left_y) * yy;
		else if (x2 <= y2)
			v34 += a * (x2 - y2) * 512 + c * (yy - xx);
		else
			u34 += a * (y2 - x2) * 512 + c * (xx - yy);
		// floor to Q.16 through the arithmetic shift
		p = (longint'(N) <<< 16) - (v34 >>> 18) - 32768;
		q = (u34 >>> 18) - 32768;
		if (p < 0 || p > (longint'(N - 1) <<< 16) || q < 0 || q > (longint'(N - 1) <<< 16))
			return s;
		s.outside = 0;
		s.r0 = int'(p >>> 16);
		s.c0 = int'(q >>> 16);
		s.fp = int'(p & 64'hFFFF);
		s.fq = int'(q & 64'hFFFF);
		return s;
	endfunction
endpackage

module warp_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire qpiw_pkg::in_item_t   in_data,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire qpiw_pkg::out_item_t  out_data,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	output int                        errors,
	output int                        pending
);
	import qpiw_pkg::*;
	import warp_map_pkg::*;

	logic [23:0] frame [0:N*N-1];
	gains_t gains;
	out_item_t warped_q [$];

	assign pending = warped_q.size();

	function automatic logic [7:0] chan(logic [23:0] px, int ch);
		return px[23 - 8 * ch -: 8];
	endfunction

	function automatic out_item_t warp_pixel(in_item_t it);
		src_pt_t s;
		longint unsigned acc [3];
		longint unsigned wp0, wq0;
		out_item_t r;
		r = '0;
		r.outside = 1'b1;
		s = map_source(it.row, it.col, gains);
		if (s.outside)
			return r;
		wp0 = 65536 - s.fp;
		wq0 = 65536 - s.fq;
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = chan(frame[s.r0 * N + s.c0], ch) * wp0 * wq0;
			if (s.fp != 0)
				acc[ch] += chan(frame[(s.r0 + 1) * N + s.c0], ch) * s.fp * wq0;
			if (s.fq != 0)
				acc[ch] += chan(frame[s.r0 * N + s.c0 + 1], ch) * wp0 * s.fq;
			if (s.fp != 0 && s.fq != 0)
				acc[ch] += chan(frame[(s.r0 + 1) * N + s.c0 + 1], ch) * s.fp * s.fq;
		end
		r.red_out = acc[0][39:32];
		r.green_out = acc[1][39:32];
		r.blue_out = acc[2][39:32];
		r.outside = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors <= 0;
			gains <= {RST_DIAG_LIN, RST_DIAG_QUAD, RST_LEFT_LIN, RST_LEFT_QX, RST_LEFT_QY};
			warped_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (warped_q.size() == 0) begin
					$error("result beat with nothing expected");
					errors <= errors + 1;
				end else begin
					out_item_t e;
					e = warped_q.pop_front();
					if (e != out_data) begin
						if (e.red_out != out_data.red_out)
							$error("red_out: expected %0d, got %0d", e.red_out, out_data.red_out);
						if (e.green_out != out_data.green_out)
							$error("green_out: expected %0d, got %0d", e.green_out,
								out_data.green_out);
						if (e.blue_out != out_data.blue_out)
							$error("blue_out: expected %0d, got %0d", e.blue_out,
								out_data.blue_out);
						if (e.outside != out_data.outside)
							$error("outside: expected %0d, got %0d", e.outside, out_data.outside);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.opcode == OP_STORE) begin
					if (in_data.row < N && in_data.col < N)
						frame[in_data.row * N + in_data.col] <=
							{in_data.red_in, in_data.green_in, in_data.blue_in};
				end else
					warped_q.push_back(warp_pixel(in_data));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DIAG_LIN: gains.lin_diag <= cfg_data[LIN_W-1:0];
					REG_DIAG_QUAD: gains.quad_diag <= cfg_data;
					REG_LEFT_LIN: gains.lin_left <= cfg_data[LIN_W-1:0];
					REG_LEFT_QX: gains.quad_left_x <= cfg_data;
					REG_LEFT_QY: gains.quad_left_y <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

[tb/tb_quadrant_polynomial_image_warp.sv]
// Stimulus, handshake pacing and verdict for the quadrant polynomial image warp.
`timescale 1ns / 1ps
module tb_quadrant_polynomial_image_warp;
	import qpiw_pkg::*;
	import warp_map_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 270;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int errors;
	int pending;

	int idle_pct = 0;
	int stall_pct = 0;
	int items = 0;
	int quiet_cycles = 0;
	bit stored [0:N*N-1];
	gains_t gains;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	quadrant_polynomial_image_warp DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	warp_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always @(negedge clk)
		out_stall = ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_beat(in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (in_stall);
		items++;
	endtask

	task automatic store_pixel(int row, int col, logic [23:0] rgb);
		in_item_t it;
		it = {OP_STORE, 9'(row), 9'(col), rgb};
		if (row < N && col < N)
			stored[row * N + col] = 1'b1;
		send_beat(it);
	endtask

	// Fill each source neighbour the query will read that is not yet stored, then issue it.
	task automatic query_pixel(int row, int col);
		src_pt_t s;
		in_item_t it;
		s = map_source(9'(row), 9'(col), gains);
		if (!s.outside) begin
			if (!stored[s.r0 * N + s.c0] || $urandom_range(3) == 0)
				store_pixel(s.r0, s.c0, 24'($urandom));
			if (s.fp != 0 && !stored[(s.r0 + 1) * N + s.c0])
				store_pixel(s.r0 + 1, s.c0, 24'($urandom));
			if (s.fq != 0 && !stored[s.r0 * N + s.c0 + 1])
				store_pixel(s.r0, s.c0 + 1, 24'($urandom));
			if (s.fp != 0 && s.fq != 0 && !stored[(s.r0 + 1) * N + s.c0 + 1])
				store_pixel(s.r0 + 1, s.c0 + 1, 24'($urandom));
		end
		it = {OP_QUERY, 9'(row), 9'(col), 24'($urandom)};
		send_beat(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		case (idx)
			REG_DIAG_LIN: gains.lin_diag = value[LIN_W-1:0];
			REG_DIAG_QUAD: gains.quad_diag = value;
			REG_LEFT_LIN: gains.lin_left = value[LIN_W-1:0];
			REG_LEFT_QX: gains.quad_left_x = value;
			REG_LEFT_QY: gains.quad_left_y = value;
			default: ;
		endcase
	endtask

	task automatic write_gains(gains_t g);
		write_reg(REG_DIAG_LIN, 32'(g.lin_diag));
		write_reg(REG_DIAG_QUAD, g.quad_diag);
		write_reg(REG_LEFT_LIN, 32'(g.lin_left));
		write_reg(REG_LEFT_QX, g.quad_left_x);
		write_reg(REG_LEFT_QY, g.quad_left_y);
	endtask

	task automatic random_items(int count);
		int start;
		int pick;
		start = items;
		while (items - start < count) begin
			pick = $urandom_range(99);
			if (pick < 10)
				store_pixel($urandom_range(511), $urandom_range(511), 24'($urandom));
			else if (pick < 16)
				query_pixel($urandom_range(N, 511), $urandom_range(511));
			else if (pick < 20)
				query_pixel($urandom_range(511), $urandom_range(N, 511));
			else if (pick < 30) begin
				// points on a diagonal, where triangles meet
				int r;
				r = $urandom_range(N - 1);
				query_pixel(r, ($urandom_range(1) ? r : N - 1 - r) + $urandom_range(2) - 1 < 0 ?
					0 : (($urandom_range(1) ? r : N - 1 - r) % N));
			end else
				query_pixel($urandom_range(N - 1), $urandom_range(N - 1));
		end
	endtask

	initial begin
		gains_t g;
		int idle_set [5] = '{0, 65, 0, 18, 0};
		int stall_set [5] = '{0, 0, 65, 18, 0};
		gains = {RST_DIAG_LIN, RST_DIAG_QUAD, RST_LEFT_LIN, RST_LEFT_QX, RST_LEFT_QY};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corners, centre, diagonals, sample extremes, out of range
		store_pixel(511, 511, 24'hFFFFFF);
		store_pixel(N, 0, 24'h000000);
		store_pixel(0, 0, 24'hFFFFFF);
		store_pixel(N - 1, N - 1, 24'h000000);
		query_pixel(0, 0);
		query_pixel(0, N - 1);
		query_pixel(N - 1, 0);
		query_pixel(N - 1, N - 1);
		query_pixel(N / 2, N / 2);
		query_pixel(100, 100);
		query_pixel(100, N - 101);
		query_pixel(10, 200);
		query_pixel(200, 10);
		query_pixel(300, 150);
		query_pixel(150, 300);
		query_pixel(N, 5);
		query_pixel(5, 511);
		query_pixel(511, 511);

		for (int ph = 0; ph < 5; ph++) begin
			idle_pct = idle_set[ph];
			stall_pct = stall_set[ph];
			if (ph > 0) begin
				drain();
				case (ph)
					1: g = '0;
					2: g = '1;
					3: begin
						g.lin_diag = RST_DIAG_LIN + $urandom_range(1 << 19) - (1 << 18);
						g.quad_diag = RST_DIAG_QUAD + $urandom_range(1 << 22) - (1 << 21);
						g.lin_left = RST_LEFT_LIN + $urandom_range(1 << 19) - (1 << 18);
						g.quad_left_x = RST_LEFT_QX + $urandom_range(1 << 22) - (1 << 21);
						g.quad_left_y = RST_LEFT_QY + $urandom_range(1 << 22) - (1 << 21);
					end
					default: g = {RST_DIAG_LIN, RST_DIAG_QUAD, RST_LEFT_LIN, RST_LEFT_QX,
						RST_LEFT_QY};
				endcase
				write_gains(g);
				// indexes past the list must leave the gains alone
				write_reg(3'($urandom_range(5, 7)), $urandom);
				// zero gains give an exact identity map, so directed corners again
				if (ph == 1) begin
					query_pixel(0, 0);
					query_pixel(N - 1, N - 1);
				end
			end
			random_items(PHASE_ITEMS);
		end

		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
